@@ rtl/core/subscription_slot_admission_macros.svh @@
`ifndef SUBSCRIPTION_SLOT_ADMISSION_MACROS_SVH
`define SUBSCRIPTION_SLOT_ADMISSION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssa assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssa assertion failed");

`endif

@@ rtl/core/ssa_pkg.sv @@
package ssa_pkg;

    localparam int ACTIVE_SLOTS_DEF  = 8;
    localparam int BACKLOG_DEPTH_DEF = 64;

    localparam int ID_W      = 31;
    localparam int MODE_W    = 2;
    localparam int KIND_W    = 3;
    localparam int ACT_CNT_W = 4;
    localparam int BL_CNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_RETRY  = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ISSUED     = 3'd0,
        KIND_QUEUED     = 3'd1,
        KIND_DROPPED    = 3'd2,
        KIND_CANCELLED  = 3'd3,
        KIND_NOT_FOUND  = 3'd4,
        KIND_QUERY      = 3'd5,
        KIND_NO_PROMOTE = 3'd6
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic take;     // latch request, read backlog head
        logic lookup;   // compare id against active slots
        logic apply;    // update state, load first result
        logic emit2;    // load promoted-id result
    } ssa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic two_results;
    } ssa_sts_t;

endpackage

@@ rtl/core/ssa_req_if.sv @@
interface ssa_req_if import ssa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   request_id;

    modport source (output valid, mode, request_id, input ready);
    modport sink (input valid, mode, request_id, output ready);
endinterface

@@ rtl/core/ssa_res_if.sv @@
interface ssa_res_if import ssa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      result_id;
    logic                 is_active;
    logic [ACT_CNT_W-1:0] active_count;
    logic [BL_CNT_W-1:0]  backlog_count;
    logic                 last;

    modport source (output valid, kind, result_id, is_active, active_count,
                    backlog_count, last, input ready);
    modport sink (input valid, kind, result_id, is_active, active_count,
                  backlog_count, last, output ready);
endinterface

@@ rtl/core/ssa_ram.sv @@
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ssa_ctrl.sv @@
module ssa_ctrl import ssa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ssa_sts_t sts,
    output ssa_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_EMIT2  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // hold until the result register can take the result
                if (sts.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = sts.two_results ? ST_EMIT2 : ST_IDLE;
                end
            end
            ST_EMIT2:
            begin
                if (sts.out_free)
                begin
                    cmd.emit2  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/ssa_datapath.sv @@
module ssa_datapath import ssa_pkg::*; #(
    parameter int ACTIVE_SLOTS  = ACTIVE_SLOTS_DEF,
    parameter int BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [ID_W-1:0]   in_id,
    input  ssa_cmd_t          cmd,
    output ssa_sts_t          sts,
    ssa_res_if.source         res
);

    localparam int UW = $clog2(ACTIVE_SLOTS + 1);
    localparam int PW = $clog2(BACKLOG_DEPTH);
    localparam int BW = $clog2(BACKLOG_DEPTH + 1);

    mode_t                   op_reg;
    logic [ID_W-1:0]         id_reg;
    logic [ID_W-1:0]         slot_reg [ACTIVE_SLOTS];
    logic [ID_W-1:0]         slot_nbr [ACTIVE_SLOTS];
    logic [ACTIVE_SLOTS-1:0] hit_reg;
    logic [UW-1:0]           used_reg, used_next;
    logic [PW-1:0]           head_reg, head_next;
    logic [PW-1:0]           tail_reg, tail_next;
    logic [BW-1:0]           bl_reg, bl_next;

    logic                    out_valid_reg;
    kind_t                   out_kind_reg;
    logic [ID_W-1:0]         out_id_reg;
    logic                    out_act_reg;
    logic [ACT_CNT_W-1:0]    out_acnt_reg;
    logic [BL_CNT_W-1:0]     out_bcnt_reg;
    logic                    out_last_reg;

    kind_t                   r_kind;
    logic [ID_W-1:0]         r_id;
    logic                    r_act;
    logic [UW-1:0]           r_acnt;
    logic [BW-1:0]           r_bcnt;
    logic                    r_last;

    logic [ID_W-1:0]         head_data;
    logic                    can_admit, bl_room, bl_any, found;
    logic [ACTIVE_SLOTS-1:0] lowest_hit, below_hit;
    logic [UW-1:0]           used_dec;
    logic [PW-1:0]           head_inc, tail_inc;
    logic                    do_admit, do_queue, do_remove;
    logic                    do_prom_retry, do_prom_cancel;
    logic                    load_out;

    assign can_admit  = used_reg < UW'(ACTIVE_SLOTS);
    assign bl_room    = bl_reg < BW'(BACKLOG_DEPTH);
    assign bl_any     = bl_reg != '0;
    assign found      = |hit_reg;
    // isolate the lowest matching slot; slots at or above it close up
    assign lowest_hit = hit_reg & (~hit_reg + ACTIVE_SLOTS'(1));
    assign below_hit  = lowest_hit - ACTIVE_SLOTS'(1);
    assign used_dec   = used_reg - UW'(1);
    assign head_inc   = (head_reg == PW'(BACKLOG_DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign tail_inc   = (tail_reg == PW'(BACKLOG_DEPTH - 1)) ? '0 : tail_reg + PW'(1);

    always_comb
    begin
        used_next      = used_reg;
        bl_next        = bl_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        do_admit       = 1'b0;
        do_queue       = 1'b0;
        do_remove      = 1'b0;
        do_prom_retry  = 1'b0;
        do_prom_cancel = 1'b0;
        r_kind         = KIND_NO_PROMOTE;
        r_id           = id_reg;
        r_act          = 1'b0;
        r_acnt         = used_reg;
        r_bcnt         = bl_reg;
        r_last         = 1'b1;
        unique case (op_reg)
            MODE_SUBMIT:
            begin
                if (can_admit)
                begin
                    do_admit  = 1'b1;
                    used_next = used_reg + UW'(1);
                    r_kind    = KIND_ISSUED;
                end
                else if (bl_room)
                begin
                    do_queue  = 1'b1;
                    tail_next = tail_inc;
                    bl_next   = bl_reg + BW'(1);
                    r_kind    = KIND_QUEUED;
                end
                else
                begin
                    r_kind = KIND_DROPPED;
                end
                r_acnt = used_next;
                r_bcnt = bl_next;
            end
            MODE_CANCEL:
            begin
                if (found)
                begin
                    do_remove = 1'b1;
                    used_next = used_dec;
                    r_kind    = KIND_CANCELLED;
                    r_acnt    = used_dec;
                    r_last    = !bl_any;
                    // refill the freed slot from the backlog head
                    if (bl_any)
                    begin
                        do_prom_cancel = 1'b1;
                        used_next      = used_reg;
                        head_next      = head_inc;
                        bl_next        = bl_reg - BW'(1);
                    end
                end
                else
                begin
                    r_kind = KIND_NOT_FOUND;
                end
            end
            MODE_QUERY:
            begin
                r_kind = KIND_QUERY;
                r_act  = found;
            end
            MODE_RETRY:
            begin
                if (can_admit && bl_any)
                begin
                    do_prom_retry = 1'b1;
                    used_next     = used_reg + UW'(1);
                    head_next     = head_inc;
                    bl_next       = bl_reg - BW'(1);
                    r_kind        = KIND_ISSUED;
                    r_id          = head_data;
                    r_acnt        = used_next;
                    r_bcnt        = bl_next;
                end
                else
                begin
                    r_kind = KIND_NO_PROMOTE;
                    r_id   = '0;
                end
            end
            default:
            begin
                r_kind = KIND_NO_PROMOTE;
            end
        endcase
    end

    for (genvar g = 0; g < ACTIVE_SLOTS; g++)
    begin : g_nbr
        if (g < ACTIVE_SLOTS - 1)
        begin : g_mid
            assign slot_nbr[g] = slot_reg[g+1];
        end
        else
        begin : g_end
            assign slot_nbr[g] = slot_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= mode_t'(in_mode);
            id_reg <= in_id;
        end
        for (int p = 0; p < ACTIVE_SLOTS; p++)
        begin
            if (cmd.lookup)
            begin
                hit_reg[p] <= (slot_reg[p] == id_reg) && (UW'(p) < used_reg);
            end
            if (cmd.apply)
            begin
                if (do_admit && used_reg == UW'(p))
                begin
                    slot_reg[p] <= id_reg;
                end
                else if ((do_prom_retry && used_reg == UW'(p)) ||
                         (do_prom_cancel && used_dec == UW'(p)))
                begin
                    slot_reg[p] <= head_data;
                end
                else if (do_remove && !below_hit[p])
                begin
                    slot_reg[p] <= slot_nbr[p];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            bl_reg   <= '0;
        end
        else if (cmd.apply)
        begin
            used_reg <= used_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            bl_reg   <= bl_next;
        end
    end

    ssa_ram #(
        .WIDTH (ID_W),
        .DEPTH (BACKLOG_DEPTH)
    ) u_backlog (
        .clk   (clk),
        .we    (cmd.apply && do_queue),
        .waddr (tail_reg),
        .wdata (id_reg),
        .re    (cmd.take),
        .raddr (head_reg),
        .rdata (head_data)
    );

    // result register
    assign load_out = cmd.apply || cmd.emit2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            out_kind_reg <= r_kind;
            out_id_reg   <= r_id;
            out_act_reg  <= r_act;
            out_acnt_reg <= ACT_CNT_W'(r_acnt);
            out_bcnt_reg <= BL_CNT_W'(r_bcnt);
            out_last_reg <= r_last;
        end
        else if (cmd.emit2)
        begin
            out_kind_reg <= KIND_ISSUED;
            out_id_reg   <= head_data;
            out_act_reg  <= 1'b0;
            out_acnt_reg <= ACT_CNT_W'(used_reg);
            out_bcnt_reg <= BL_CNT_W'(bl_reg);
            out_last_reg <= 1'b1;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.kind          = out_kind_reg;
    assign res.result_id     = out_id_reg;
    assign res.is_active     = out_act_reg;
    assign res.active_count  = out_acnt_reg;
    assign res.backlog_count = out_bcnt_reg;
    assign res.last          = out_last_reg;

    assign sts.out_free    = !out_valid_reg || res.ready;
    assign sts.two_results = (op_reg == MODE_CANCEL) && found && bl_any;

endmodule

@@ rtl/core/subscription_slot_admission.sv @@
// Request slot admission. Each request (submit, cancel, query, retry) is worked
// one at a time by a small sequencer: the request is taken, the id is compared
// against all active slots in the next cycle, and then state is updated and the
// result loaded once the result register is free; a cancel that refills its slot
// from the backlog gives a second result from a separate emit step after the
// update step. The result register lets the next request be taken while a
// result still waits; a stalled result holds the sequencer in its update or
// emit step. The backlog is a single-port-write, registered-read RAM whose head
// entry is read as the request is taken. Active slots close up in order on a
// cancel; the lowest matching slot is removed. No clearing pass is needed after
// reset.
module subscription_slot_admission import ssa_pkg::*; #(
    parameter int ACTIVE_SLOTS  = ACTIVE_SLOTS_DEF,
    parameter int BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ssa_req_if.sink   req,
    ssa_res_if.source res
);

`include "subscription_slot_admission_macros.svh"

    ssa_cmd_t cmd;
    ssa_sts_t sts;
    logic     in_ready;

    assign req.ready = in_ready;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssa_datapath #(
        .ACTIVE_SLOTS  (ACTIVE_SLOTS),
        .BACKLOG_DEPTH (BACKLOG_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mode (req.mode),
        .in_id   (req.request_id),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

    `SSA_ASSERT_NEXT(a_accept_then_lookup, req.valid && req.ready, cmd.lookup && !req.ready)
    `SSA_ASSERT_NOW(a_load_needs_room, cmd.apply || cmd.emit2, sts.out_free)
    `SSA_ASSERT_NEXT(a_load_shows_result, cmd.apply || cmd.emit2, res.valid)
    `SSA_ASSERT_NEXT(a_second_follows, cmd.apply && sts.two_results, !req.ready)

endmodule

@@ bench/ssa_admission_checker.sv @@
module ssa_admission_checker import ssa_pkg::*; #(
    parameter int ACTIVE_SLOTS  = ACTIVE_SLOTS_DEF,
    parameter int BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ssa_req_if         req,
    ssa_res_if         res,
    output int         mismatches,
    output int         awaiting,
    output int         compared,
    output logic [7:0] kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      id;
        logic                 is_active;
        logic [ACT_CNT_W-1:0] active_count;
        logic [BL_CNT_W-1:0]  backlog_count;
        logic                 last;
    } admission_result_t;

    logic [ID_W-1:0]   slot_id [ACTIVE_SLOTS];
    int                slots_used;
    logic [ID_W-1:0]   backlog_q [$];
    admission_result_t outcome_q [$];

    // Counts are taken from the predicted state at the moment of the push.
    task automatic push_outcome(kind_t k, logic [ID_W-1:0] id, logic hit, logic fin);
        admission_result_t r;
        r.kind          = k;
        r.id            = id;
        r.is_active     = hit;
        r.active_count  = ACT_CNT_W'(slots_used);
        r.backlog_count = BL_CNT_W'(backlog_q.size());
        r.last          = fin;
        outcome_q.push_back(r);
    endtask

    task automatic promote_head();
        logic [ID_W-1:0] pid;
        pid = backlog_q.pop_front();
        slot_id[slots_used] = pid;
        slots_used++;
        push_outcome(KIND_ISSUED, pid, 1'b0, 1'b1);
    endtask

    task automatic admit(mode_t m, logic [ID_W-1:0] id);
        int  hit_at;
        int  i;
        logic refill;
        hit_at = -1;
        for (i = 0; i < slots_used; i++)
        begin
            if (hit_at < 0 && slot_id[i] == id)
                hit_at = i;
        end
        case (m)
            MODE_SUBMIT:
            begin
                if (slots_used < ACTIVE_SLOTS)
                begin
                    slot_id[slots_used] = id;
                    slots_used++;
                    push_outcome(KIND_ISSUED, id, 1'b0, 1'b1);
                end
                else if (backlog_q.size() < BACKLOG_DEPTH)
                begin
                    backlog_q.push_back(id);
                    push_outcome(KIND_QUEUED, id, 1'b0, 1'b1);
                end
                else
                    push_outcome(KIND_DROPPED, id, 1'b0, 1'b1);
            end
            MODE_CANCEL:
            begin
                if (hit_at < 0)
                    push_outcome(KIND_NOT_FOUND, id, 1'b0, 1'b1);
                else
                begin
                    // close up the later slots, keeping their order
                    for (i = hit_at; i + 1 < slots_used; i++)
                        slot_id[i] = slot_id[i + 1];
                    slots_used--;
                    refill = (backlog_q.size() != 0);
                    push_outcome(KIND_CANCELLED, id, 1'b0, !refill);
                    if (refill)
                        promote_head();
                end
            end
            MODE_QUERY:
                push_outcome(KIND_QUERY, id, hit_at >= 0, 1'b1);
            default:
            begin
                if (slots_used < ACTIVE_SLOTS && backlog_q.size() != 0)
                    promote_head();
                else
                    push_outcome(KIND_NO_PROMOTE, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        admission_result_t seen;
        admission_result_t want;
        if (!rst_n)
        begin
            slots_used = 0;
            backlog_q.delete();
            outcome_q.delete();
            mismatches = 0;
            compared   = 0;
            kinds_seen = '0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                seen.kind          = kind_t'(res.kind);
                seen.id            = res.result_id;
                seen.is_active     = res.is_active;
                seen.active_count  = res.active_count;
                seen.backlog_count = res.backlog_count;
                seen.last          = res.last;
                compared++;
                kinds_seen[res.kind] = 1'b1;
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got kind=%0d id=%0h act=%0b",
                             $time, seen.kind, seen.id, seen.is_active,
                             " slots=%0d backlog=%0d last=%0b",
                             seen.active_count, seen.backlog_count, seen.last);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected kind=%0d id=%0h act=%0b slots=%0d",
                                 $time, want.kind, want.id, want.is_active,
                                 want.active_count,
                                 " backlog=%0d last=%0b", want.backlog_count, want.last);
                        $display("%0t:          actual kind=%0d id=%0h act=%0b slots=%0d",
                                 $time, seen.kind, seen.id, seen.is_active,
                                 seen.active_count,
                                 " backlog=%0d last=%0b", seen.backlog_count, seen.last);
                    end
                end
            end
            if (req.valid && req.ready)
                admit(mode_t'(req.mode), req.request_id);
        end
        awaiting = outcome_q.size();
    end

endmodule

@@ bench/subscription_slot_admission_tb.sv @@
module subscription_slot_admission_tb import ssa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_MAX       = 96;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         awaiting;
    int         compared;
    logic [7:0] kinds_seen;
    int         idle_cycles;
    int         sent_by_mode [4];
    int         sender_gap_pct;
    int         sink_stall_pct;

    logic [ID_W-1:0] id_pool [$];

    ssa_req_if req_ch();
    ssa_res_if res_ch();

    subscription_slot_admission i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    ssa_admission_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting),
        .compared   (compared),
        .kinds_seen (kinds_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Hold the request until it is taken; valid stays high for the caller.
    task automatic send_request(mode_t m, logic [ID_W-1:0] id);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.request_id <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_by_mode[m]++;
        if (m == MODE_SUBMIT)
        begin
            id_pool.push_back(id);
            if (id_pool.size() > POOL_MAX)
                void'(id_pool.pop_front());
        end
    endtask

    task automatic pause_sender(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(1, 100) <= sender_gap_pct)
            pause_sender($urandom_range(1, 19));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // Mostly a small id space so cancels and queries hit; the rest covers every bit.
    function automatic logic [ID_W-1:0] fresh_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return ID_W'($urandom_range(0, 15));
        else if (sel < 9)
            return ID_W'($urandom);
        else
            return $urandom_range(0, 1) ? ID_MAX : '0;
    endfunction

    task automatic random_request(int w_submit, int w_cancel, int w_query);
        int roll;
        int idx;
        logic [ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        if (roll < w_submit)
            send_request(MODE_SUBMIT, fresh_id());
        else if (roll < w_submit + w_cancel)
        begin
            // pick among the oldest submits, which are most likely active
            if (id_pool.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                idx = $urandom_range(0, (id_pool.size() > 12) ? 11 : id_pool.size() - 1);
                id = id_pool[idx];
                id_pool.delete(idx);
            end
            else
                id = fresh_id();
            send_request(MODE_CANCEL, id);
        end
        else if (roll < w_submit + w_cancel + w_query)
        begin
            if (id_pool.size() != 0 && $urandom_range(0, 1) != 0)
                id = id_pool[$urandom_range(0, id_pool.size() - 1)];
            else
                id = fresh_id();
            send_request(MODE_QUERY, id);
        end
        else
            send_request(MODE_RETRY, ID_W'($urandom));
        maybe_gap();
    endtask

    task automatic random_phase(int count, int w_submit, int w_cancel, int w_query);
        repeat (count) random_request(w_submit, w_cancel, w_query);
    endtask

    task automatic directed_request(mode_t m, logic [ID_W-1:0] id);
        send_request(m, id);
        maybe_gap();
    endtask

    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_stall_pct)
            begin
                stall = $urandom_range(1, 19) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // End the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        sender_gap_pct    = 20;
        sink_stall_pct    = 10;
        sent_by_mode      = '{default: 0};
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_SUBMIT;
        req_ch.request_id <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty block: miss, nothing to promote, cancel of an absent id
        directed_request(MODE_QUERY, '0);
        directed_request(MODE_RETRY, ID_MAX);
        directed_request(MODE_CANCEL, ID_MAX);
        // fill every slot, with a duplicate and the extreme ids
        directed_request(MODE_SUBMIT, '0);
        directed_request(MODE_SUBMIT, ID_MAX);
        directed_request(MODE_SUBMIT, 31'h2AAA_AAAA);
        directed_request(MODE_SUBMIT, 31'h5555_5555);
        directed_request(MODE_SUBMIT, 31'd5);
        directed_request(MODE_SUBMIT, 31'd5);
        directed_request(MODE_SUBMIT, 31'd9);
        directed_request(MODE_SUBMIT, 31'd12);
        directed_request(MODE_SUBMIT, 31'd100);
        directed_request(MODE_SUBMIT, 31'd101);
        directed_request(MODE_QUERY, 31'd5);
        // backlog entries are not active and cannot be cancelled
        directed_request(MODE_QUERY, 31'd100);
        directed_request(MODE_RETRY, '0);
        directed_request(MODE_CANCEL, 31'd100);
        // cancel with refill from the backlog, lowest duplicate first
        directed_request(MODE_CANCEL, 31'd5);
        directed_request(MODE_QUERY, 31'd5);
        directed_request(MODE_CANCEL, ID_MAX);
        // cancel with an empty backlog, then retry with a free slot
        directed_request(MODE_CANCEL, '0);
        directed_request(MODE_RETRY, '0);
        directed_request(MODE_SUBMIT, '0);
        drain_results();

        sender_gap_pct = 25;
        sink_stall_pct = 12;
        random_phase(120, 40, 30, 20);

        // overfill the backlog so submits get dropped
        sender_gap_pct = 10;
        sink_stall_pct = 5;
        random_phase(110, 85, 0, 10);
        drain_results();

        sender_gap_pct = 30;
        sink_stall_pct = 20;
        random_phase(120, 15, 60, 15);

        sender_gap_pct = 0;
        sink_stall_pct = 0;
        random_phase(80, 40, 30, 20);

        drain_results();
        repeat (30) @(posedge clk);

        $display("Ran %0d submits, %0d cancels, %0d queries, %0d retries; %0d results checked.",
                 sent_by_mode[MODE_SUBMIT], sent_by_mode[MODE_CANCEL],
                 sent_by_mode[MODE_QUERY], sent_by_mode[MODE_RETRY], compared);
        $display("Result kinds observed (issued at bit 0): %b", kinds_seen[6:0]);
        if (mismatches == 0 && awaiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
